### src/bfsa_pkg.sv
// Package for the best-fit segment allocator: payload structs, result codes,
// controller states, datapath commands and status. No dependencies.
package bfsa_pkg;

   localparam int MAX_SEGMENTS_DEF = 64;
   localparam logic [15:0] RESET_TOTAL_SIZE = 16'd2048;

   localparam logic [2:0] RC_OK       = 3'd0;
   localparam logic [2:0] RC_NOFIT    = 3'd1;
   localparam logic [2:0] RC_FULL     = 3'd2;
   localparam logic [2:0] RC_NOTFOUND = 3'd3;
   localparam logic [2:0] RC_ZERO     = 3'd4;

   typedef struct packed {
      logic        req_type;
      logic [15:0] req_size;
      logic [15:0] req_location;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  result_code;
      logic [15:0] result_location;
   } rsp_item_type;

   typedef struct packed {
      logic [15:0] start;
      logic [15:0] length;
      logic        free;
   } seg_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_A_RD, ST_A_EV, ST_A_DEC, ST_UP_CHK, ST_UP_WR, ST_WR_REST,
      ST_WR_FRONT, ST_F_RD, ST_F_EV, ST_NX_RD, ST_NX_EV, ST_MRG, ST_DN_CHK,
      ST_DN_WR, ST_FIN
   } st_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_START, OP_A_READ, OP_A_EVAL, OP_A_DEC, OP_UP_READ,
      OP_UP_WRITE, OP_WR_REST, OP_WR_FRONT, OP_F_READ, OP_F_EVAL, OP_NX_READ,
      OP_NX_EVAL, OP_MERGE, OP_DN_READ, OP_DN_WRITE, OP_RESULT
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [2:0] code;
   } cmd_type;

   typedef struct packed {
      logic start_free;
      logic start_zero;
      logic scan_end;
      logic found;
      logic exact;
      logic full;
      logic up_done;
      logic hit;
      logic hit_free;
      logic merge_none;
      logic dn_end;
      logic rsp_busy;
   } sts_type;

endpackage

### src/best_fit_segment_allocator_top.sv
// Best-fit segment allocator, top level. Alloc scans the whole table for the best fit,
// then on a split shifts the entries above it up by one and writes the rest and front parts;
// free scans for the entry that starts at the given location, marks it free, merges it with
// free neighbours and shifts the following entries down. One item at a time; the next is
// accepted in the cycle after the result is loaded.
// Reset (synchronous): one free segment of 2048 units, written during reset.
// Depends on bfsa_pkg, bfsa_controller, bfsa_datapath.
module best_fit_segment_allocator_top import bfsa_pkg::*; #(
   parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_data,
   input  logic         csr_we,
   input  logic [15:0]  csr_wdata
);

   // command and status between sequencer and table datapath
   cmd_type cmd;
   sts_type sts;

   // sequencer: accepts an item only when idle; the result register in the
   // datapath holds a finished item until the far side takes it
   bfsa_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // segment table (start, length, free mark) in a registered-read memory;
   // a total-size write re-lays entry 0 and sets the count back to one
   bfsa_datapath #(
      .MAX_SEGMENTS (MAX_SEGMENTS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

### src/bfsa_datapath.sv
// Datapath: segment table memory, scan/shift counters, result register.
// Depends on bfsa_pkg; driven by bfsa_controller commands.
module bfsa_datapath import bfsa_pkg::*; #(
   parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  req_item_type req_data,
   input  logic         rsp_ready,
   output logic         rsp_valid,
   output rsp_item_type rsp_data,
   input  logic         csr_we,
   input  logic [15:0]  csr_wdata,
   input  cmd_type      cmd,
   output sts_type      sts
);

   localparam int IW = $clog2(MAX_SEGMENTS);
   localparam int CW = $clog2(MAX_SEGMENTS + 1);
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SEGMENTS);

   seg_type mem [MAX_SEGMENTS];
   seg_type rd_ff;

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [IW-1:0] best_ff, best_in;
   seg_type       best_seg_ff, best_seg_in;
   logic          found_ff, found_in;
   seg_type       prev_ff, prev_in;
   seg_type       cur_ff, cur_in;
   logic          nxt_free_ff, nxt_free_in;
   logic [15:0]   nxt_len_ff, nxt_len_in;
   logic [1:0]    k_ff, k_in;
   req_item_type  req_ff, req_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_item_type  rsp_ff, rsp_in;

   logic [CW:0]   idx_p1, idx_k, best_p1w;
   logic [CW-1:0] idx_m1;
   logic [IW-1:0] rd_addr, wa;
   logic          we;
   seg_type       wd;
   logic          fits, prev_ok;
   logic [15:0]   nxt_add;

   assign idx_p1   = {1'b0, idx_ff} + (CW+1)'(1);
   assign idx_k    = {1'b0, idx_ff} + (CW+1)'(k_ff);
   assign idx_m1   = idx_ff - CW'(1);
   assign best_p1w = (CW+1)'(best_ff) + (CW+1)'(1);
   assign fits     = rd_ff.free && (rd_ff.length >= req_ff.req_size) &&
                     (!found_ff || (rd_ff.length < best_seg_ff.length));
   assign prev_ok  = (idx_ff != '0) && prev_ff.free;
   assign nxt_add  = nxt_free_ff ? nxt_len_ff : 16'd0;

   always_comb begin
      sts.start_free = req_data.req_type;
      sts.start_zero = (req_data.req_size == 16'd0);
      sts.scan_end   = (idx_ff == count_ff);
      sts.found      = found_ff;
      sts.exact      = (best_seg_ff.length == req_ff.req_size);
      sts.full       = (count_ff == MAX_CNT);
      sts.up_done    = (best_p1w == {1'b0, idx_ff});
      sts.hit        = (rd_ff.start == req_ff.req_location);
      sts.hit_free   = rd_ff.free;
      sts.merge_none = !prev_ok && !nxt_free_ff;
      sts.dn_end     = (idx_k >= {1'b0, count_ff});
      sts.rsp_busy   = rsp_valid_ff && !rsp_ready;
   end

   always_comb begin
      case (cmd.op)
         OP_UP_READ: rd_addr = idx_m1[IW-1:0];
         OP_NX_READ: rd_addr = idx_p1[IW-1:0];
         OP_DN_READ: rd_addr = idx_k[IW-1:0];
         default:    rd_addr = idx_ff[IW-1:0];
      endcase
   end

   // table write port; reset and register writes lay down the single free segment
   always_comb begin
      we = 1'b0;
      wa = '0;
      wd = '{start: 16'd0, length: RESET_TOTAL_SIZE, free: 1'b1};
      if (reset) begin
         we = 1'b1;
      end else if (csr_we) begin
         we = 1'b1;
         wd = '{start: 16'd0, length: csr_wdata, free: 1'b1};
      end else begin
         case (cmd.op)
            OP_A_DEC: begin
               we = found_ff && sts.exact;
               wa = best_ff;
               wd = '{start: best_seg_ff.start, length: best_seg_ff.length, free: 1'b0};
            end
            OP_UP_WRITE, OP_DN_WRITE: begin
               we = 1'b1;
               wa = idx_ff[IW-1:0];
               wd = rd_ff;
            end
            OP_WR_REST: begin
               we = 1'b1;
               wa = best_p1w[IW-1:0];
               wd = '{start: best_seg_ff.start + req_ff.req_size,
                      length: best_seg_ff.length - req_ff.req_size, free: 1'b1};
            end
            OP_WR_FRONT: begin
               we = 1'b1;
               wa = best_ff;
               wd = '{start: best_seg_ff.start, length: req_ff.req_size, free: 1'b0};
            end
            OP_MERGE: begin
               we = 1'b1;
               if (prev_ok) begin
                  wa = idx_m1[IW-1:0];
                  wd = '{start: prev_ff.start,
                         length: prev_ff.length + cur_ff.length + nxt_add, free: 1'b1};
               end else begin
                  wa = idx_ff[IW-1:0];
                  wd = '{start: cur_ff.start, length: cur_ff.length + nxt_add,
                         free: 1'b1};
               end
            end
            default: we = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rd_ff <= mem[rd_addr];
   end

   always_comb begin
      count_in     = count_ff;
      idx_in       = idx_ff;
      best_in      = best_ff;
      best_seg_in  = best_seg_ff;
      found_in     = found_ff;
      prev_in      = prev_ff;
      cur_in       = cur_ff;
      nxt_free_in  = nxt_free_ff;
      nxt_len_in   = nxt_len_ff;
      k_in         = k_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (cmd.op)
         OP_START: begin
            req_in   = req_data;
            idx_in   = '0;
            found_in = 1'b0;
         end
         OP_A_EVAL: begin
            if (fits) begin
               best_in     = idx_ff[IW-1:0];
               best_seg_in = rd_ff;
               found_in    = 1'b1;
            end
            idx_in = idx_p1[CW-1:0];
         end
         OP_A_DEC: begin
            if (found_ff && !sts.exact && !sts.full) begin
               idx_in = count_ff;
            end
         end
         OP_UP_WRITE: idx_in = idx_m1;
         OP_WR_REST:  count_in = count_ff + CW'(1);
         OP_F_EVAL: begin
            if (sts.hit) begin
               cur_in = rd_ff;
            end else begin
               prev_in = rd_ff;
               idx_in  = idx_p1[CW-1:0];
            end
         end
         OP_NX_EVAL: begin
            nxt_free_in = (idx_p1 < {1'b0, count_ff}) && rd_ff.free;
            nxt_len_in  = rd_ff.length;
         end
         OP_MERGE: begin
            if (prev_ok && nxt_free_ff) begin
               k_in = 2'd2;
            end else if (prev_ok) begin
               k_in = 2'd1;
            end else begin
               k_in   = 2'd1;
               idx_in = idx_p1[CW-1:0];
            end
         end
         OP_DN_READ: begin
            if (sts.dn_end) begin
               count_in = count_ff - CW'(k_ff);
            end
         end
         OP_DN_WRITE: idx_in = idx_p1[CW-1:0];
         OP_RESULT: begin
            if (!sts.rsp_busy) begin
               rsp_valid_in = 1'b1;
               rsp_in.result_code = cmd.code;
               if (cmd.code != RC_OK) begin
                  rsp_in.result_location = 16'd0;
               end else if (req_ff.req_type) begin
                  rsp_in.result_location = req_ff.req_location;
               end else begin
                  rsp_in.result_location = best_seg_ff.start;
               end
            end
         end
         default: count_in = count_ff;
      endcase
      if (csr_we) begin
         count_in = CW'(1);
         idx_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= CW'(1);
         idx_ff       <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      best_ff     <= best_in;
      best_seg_ff <= best_seg_in;
      prev_ff     <= prev_in;
      cur_ff      <= cur_in;
      nxt_free_ff <= nxt_free_in;
      nxt_len_ff  <= nxt_len_in;
      k_ff        <= k_in;
      req_ff      <= req_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (count_ff >= CW'(1)) && (count_ff <= MAX_CNT))
      else $error("segment count out of range");
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= count_ff)
      else $error("table index beyond segment count");
   a_err_loc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.result_code != RC_OK) |-> rsp_ff.result_location == 16'd0)
      else $error("error result with non-zero location");

endmodule

### src/bfsa_controller.sv
// Controller FSM: sequences scan, shift and merge steps of the datapath.
// Depends on bfsa_pkg; talks to bfsa_datapath through cmd/sts structs.
module bfsa_controller import bfsa_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   st_type     state_ff, state_in;
   logic [2:0] code_ff, code_in;

   always_comb begin
      state_in = state_ff;
      code_in  = code_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (sts.start_free) begin
                  state_in = ST_F_RD;
               end else if (sts.start_zero) begin
                  state_in = ST_FIN;
                  code_in  = RC_ZERO;
               end else begin
                  state_in = ST_A_RD;
               end
            end
         end
         ST_A_RD: state_in = sts.scan_end ? ST_A_DEC : ST_A_EV;
         ST_A_EV: state_in = ST_A_RD;
         ST_A_DEC: begin
            state_in = ST_FIN;
            if (!sts.found) begin
               code_in = RC_NOFIT;
            end else if (sts.exact) begin
               code_in = RC_OK;
            end else if (sts.full) begin
               code_in = RC_FULL;
            end else begin
               state_in = ST_UP_CHK;
            end
         end
         ST_UP_CHK:   state_in = sts.up_done ? ST_WR_REST : ST_UP_WR;
         ST_UP_WR:    state_in = ST_UP_CHK;
         ST_WR_REST:  state_in = ST_WR_FRONT;
         ST_WR_FRONT: begin
            state_in = ST_FIN;
            code_in  = RC_OK;
         end
         ST_F_RD: begin
            if (sts.scan_end) begin
               state_in = ST_FIN;
               code_in  = RC_NOTFOUND;
            end else begin
               state_in = ST_F_EV;
            end
         end
         ST_F_EV: begin
            if (!sts.hit) begin
               state_in = ST_F_RD;
            end else if (sts.hit_free) begin
               state_in = ST_FIN;
               code_in  = RC_NOTFOUND;
            end else begin
               state_in = ST_NX_RD;
            end
         end
         ST_NX_RD: state_in = ST_NX_EV;
         ST_NX_EV: state_in = ST_MRG;
         ST_MRG: begin
            code_in  = RC_OK;
            state_in = sts.merge_none ? ST_FIN : ST_DN_CHK;
         end
         ST_DN_CHK: state_in = sts.dn_end ? ST_FIN : ST_DN_WR;
         ST_DN_WR:  state_in = ST_DN_CHK;
         ST_FIN:    state_in = sts.rsp_busy ? ST_FIN : ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd.code  = code_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.op    = req_valid ? OP_START : OP_NONE;
         end
         ST_A_RD:     cmd.op = OP_A_READ;
         ST_A_EV:     cmd.op = OP_A_EVAL;
         ST_A_DEC:    cmd.op = OP_A_DEC;
         ST_UP_CHK:   cmd.op = OP_UP_READ;
         ST_UP_WR:    cmd.op = OP_UP_WRITE;
         ST_WR_REST:  cmd.op = OP_WR_REST;
         ST_WR_FRONT: cmd.op = OP_WR_FRONT;
         ST_F_RD:     cmd.op = OP_F_READ;
         ST_F_EV:     cmd.op = OP_F_EVAL;
         ST_NX_RD:    cmd.op = OP_NX_READ;
         ST_NX_EV:    cmd.op = OP_NX_EVAL;
         ST_MRG:      cmd.op = OP_MERGE;
         ST_DN_CHK:   cmd.op = OP_DN_READ;
         ST_DN_WR:    cmd.op = OP_DN_WRITE;
         ST_FIN:      cmd.op = OP_RESULT;
         default:     cmd.op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         code_ff  <= RC_OK;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

endmodule

### tb/sv/best_fit_segment_allocator_top_test.sv
// Self-checking bench for best_fit_segment_allocator_top: a driver and a monitor
// against an in-bench model of the best-fit segment table with coalescing.
// Depends on bfsa_pkg and the RTL of best_fit_segment_allocator_top.
module best_fit_segment_allocator_top_test;
   import bfsa_pkg::*;

   localparam int SEGS        = MAX_SEGMENTS_DEF;
   localparam int IDLE_LIMIT  = 4000;   // cycles with no handshake on either side
   localparam int HOLD_CYCLES = 500;    // the one long receiver hold-off
   localparam int SETTLE      = 4 * SEGS + 16;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_item_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_item_type rsp_data;
   logic         csr_we    = 1'b0;
   logic [15:0]  csr_wdata = '0;

   best_fit_segment_allocator_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   // Shadow of the segment table: address ordered, tiles [0, mem_size).
   logic [15:0] seg_base [SEGS];
   logic [15:0] seg_len  [SEGS];
   bit          seg_free [SEGS];
   int          seg_used;
   logic [15:0] mem_size;

   req_item_type req_backlog[$];         // items waiting for the driver
   rsp_item_type predicted_results[$];   // outcomes still owed by the block
   int           error_count   = 0;
   int           results_seen  = 0;
   bit           no_idling     = 1'b0;   // set for stretches at full rate

   // Driver and monitor bookkeeping
   int  send_gap   = 0;
   int  recv_stall = 0;
   int  hold_left  = 0;
   bit  hold_done  = 1'b0;
   int  idle_count = 0;

   function automatic void table_clear(logic [15:0] size);
      mem_size = size;
      for (int k = 0; k < SEGS; k++) begin
         seg_base[k] = '0;
         seg_len[k]  = '0;
         seg_free[k] = 1'b0;
      end
      seg_len[0]  = size;
      seg_free[0] = 1'b1;
      seg_used    = 1;
   endfunction

   function automatic void drop_entry(int k);
      for (int j = k; j + 1 < seg_used; j++) begin
         seg_base[j] = seg_base[j+1];
         seg_len[j]  = seg_len[j+1];
         seg_free[j] = seg_free[j+1];
      end
      seg_used--;
   endfunction

   // Applies one accepted item to the shadow table and returns its outcome.
   function automatic rsp_item_type allocate_or_release(req_item_type r);
      rsp_item_type res;
      int best;
      int i;
      bit found;
      res   = '0;
      best  = 0;
      found = 1'b0;
      if (r.req_type == 1'b0) begin
         if (r.req_size == 16'd0) begin
            res.result_code = RC_ZERO;
         end else begin
            for (i = 0; i < seg_used; i++)
               if (seg_free[i] && seg_len[i] >= r.req_size &&
                   (!found || seg_len[i] < seg_len[best])) begin
                  best  = i;
                  found = 1'b1;
               end
            if (!found) begin
               res.result_code = RC_NOFIT;
            end else if (seg_len[best] == r.req_size) begin
               seg_free[best]      = 1'b0;
               res.result_code     = RC_OK;
               res.result_location = seg_base[best];
            end else if (seg_used >= SEGS) begin
               res.result_code = RC_FULL;
            end else begin
               // split: front part allocated, remainder stays free behind it
               for (i = seg_used; i > best; i--) begin
                  seg_base[i] = seg_base[i-1];
                  seg_len[i]  = seg_len[i-1];
                  seg_free[i] = seg_free[i-1];
               end
               seg_used++;
               seg_len[best]       = r.req_size;
               seg_free[best]      = 1'b0;
               seg_base[best+1]    = seg_base[best] + r.req_size;
               seg_len[best+1]     = seg_len[best+1] - r.req_size;
               res.result_code     = RC_OK;
               res.result_location = seg_base[best];
            end
         end
      end else begin
         for (i = 0; i < seg_used; i++)
            if (seg_base[i] == r.req_location) break;
         if (i >= seg_used || seg_free[i]) begin
            res.result_code = RC_NOTFOUND;
         end else begin
            seg_free[i] = 1'b1;
            if (i + 1 < seg_used && seg_free[i+1]) begin
               seg_len[i] = seg_len[i] + seg_len[i+1];
               drop_entry(i + 1);
            end
            if (i > 0 && seg_free[i-1]) begin
               seg_len[i-1] = seg_len[i-1] + seg_len[i];
               drop_entry(i);
            end
            res.result_code     = RC_OK;
            res.result_location = r.req_location;
         end
      end
      return res;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d, want %0d (result %0d)", what, got, want, results_seen);
      error_count++;
   endtask

   // Unused field of each item gets random content.
   function automatic void queue_alloc(int size);
      req_item_type r;
      r.req_type     = 1'b0;
      r.req_size     = size[15:0];
      r.req_location = 16'($urandom_range(0, 65535));
      req_backlog.push_back(r);
   endfunction

   function automatic void queue_release(int loc);
      req_item_type r;
      r.req_type     = 1'b1;
      r.req_size     = 16'($urandom_range(0, 65535));
      r.req_location = loc[15:0];
      req_backlog.push_back(r);
   endfunction

   // Random item shaped by the current shadow table: mostly sensible
   // allocations and releases of live segments, the rest noise.
   function automatic void queue_random_item();
      int pick;
      int k;
      int tries;
      pick = $urandom_range(0, 99);
      k    = $urandom_range(0, seg_used - 1);
      if (pick < 50) begin
         case ($urandom_range(0, 19))
            0:       queue_alloc(0);
            1:       queue_alloc($urandom_range(0, 65535));
            2, 3:    queue_alloc(int'(seg_len[k]));
            default: queue_alloc($urandom_range(1, mem_size / 12 + 1));
         endcase
      end else if (pick < 90) begin
         tries = 0;
         while (seg_free[k] && tries < 8) begin
            k = $urandom_range(0, seg_used - 1);
            tries++;
         end
         queue_release(int'(seg_base[k]));
      end else if (pick < 95) begin
         queue_release(int'(seg_base[k]));
      end else begin
         queue_release($urandom_range(0, 65535));
      end
   endfunction

   // Driver: predicts at acceptance, then offers the next item after a gap.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         if (req_valid && req_ready)
            predicted_results.push_back(allocate_or_release(req_data));
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               req_valid <= 1'b0;
               send_gap  <= send_gap - 1;
            end else if (req_backlog.size() > 0) begin
               req_data  <= req_backlog.pop_front();
               req_valid <= 1'b1;
               if (no_idling || $urandom_range(0, 2) != 0)
                  send_gap <= 0;
               else if ($urandom_range(0, 9) == 0)
                  send_gap <= $urandom_range(10, 40);
               else
                  send_gap <= $urandom_range(1, 3);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each result against the oldest prediction, drives
   // rsp_ready with random stalls and one long hold, and runs the watchdog.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         idle_count <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen <= results_seen + 1;
            if (predicted_results.size() == 0) begin
               report_mismatch("unexpected result, code", rsp_data.result_code, -1);
            end else begin
               if (rsp_data.result_code !== predicted_results[0].result_code)
                  report_mismatch("result_code", rsp_data.result_code,
                                  predicted_results[0].result_code);
               if (rsp_data.result_location !== predicted_results[0].result_location)
                  report_mismatch("result_location", rsp_data.result_location,
                                  predicted_results[0].result_location);
               void'(predicted_results.pop_front());
            end
         end

         // one long hold-off once traffic is under way; the sender keeps offering
         if (!hold_done && results_seen == 150) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else if (recv_stall > 0) begin
            recv_stall <= recv_stall - 1;
            rsp_ready  <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!no_idling && $urandom_range(0, 5) == 0)
               recv_stall <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                         : $urandom_range(1, 3);
         end

         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (req_backlog.size() == 0 && !req_valid && predicted_results.size() == 0))
            idle_count <= 0;
         else
            idle_count <= idle_count + 1;
         if (idle_count >= IDLE_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // Sender pause: nothing queued, nothing in flight, then let the block settle.
   task automatic wait_drained();
      while (req_backlog.size() != 0 || req_valid || predicted_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_mem_size(logic [15:0] size);
      wait_drained();
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= size;
      @(posedge clock);
      csr_we    <= 1'b0;
      table_clear(size);
   endtask

   task automatic run_random(int count);
      for (int n = 0; n < count; n++) begin
         while (req_backlog.size() >= 2) @(posedge clock);
         queue_random_item();
      end
   endtask

   initial begin
      table_clear(RESET_TOTAL_SIZE);
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part on the reset table of 2048 units.
      queue_alloc(0);             // zero size
      queue_release(5);           // no segment starts there
      queue_alloc(100);           // split at 0
      queue_alloc(200);           // split at 100
      queue_alloc(1);             // split at 300
      queue_release(100);
      queue_release(0);           // merges with the free follower
      queue_release(0);           // already free
      queue_alloc(65535);         // nothing fits
      queue_alloc(300);           // exact fit of the merged hole
      queue_release(300);         // merges with the free tail
      queue_release(0);           // back to one segment
      queue_alloc(2048);          // exact fit of all memory
      queue_release(0);
      queue_alloc(2047);
      queue_alloc(1);             // exact fit of the last unit
      queue_release(2047);
      queue_release(0);           // merges with the free follower
      run_random(230);

      // Small memory: fill the table, then a split with no room left.
      write_mem_size(16'd100);
      for (int n = 0; n < SEGS - 1; n++) queue_alloc(1);
      queue_alloc(2);             // table full
      queue_alloc(37);            // exact fit still goes through when full
      queue_release(0);
      run_random(180);

      // Largest memory at full rate on both sides.
      write_mem_size(16'hFFFF);
      no_idling = 1'b1;
      run_random(180);
      wait_drained();
      no_idling = 1'b0;

      write_mem_size(16'd1);
      queue_alloc(1);
      run_random(50);

      write_mem_size(16'd0);      // empty memory: nothing can ever fit
      queue_alloc(1);
      queue_release(0);
      run_random(40);

      write_mem_size(16'($urandom_range(200, 4000)));
      run_random(200);

      wait_drained();
      if (error_count == 0 && predicted_results.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

### best_fit_segment_allocator_top.f
src/bfsa_pkg.sv
src/bfsa_datapath.sv
src/bfsa_controller.sv
src/best_fit_segment_allocator_top.sv
tb/sv/best_fit_segment_allocator_top_test.sv
